/* rtl/core/i64div_pkg.sv */
// i64div_pkg: shared types and codes for the pipelined 64-bit divider.
// No dependencies; imported by the divider top level and its checker.
`default_nettype none

package i64div_pkg;

  // Port width of operand and answer fields
  localparam int unsigned WORD_W = 64;

  // Operation codes carried on req_type
  typedef enum logic [1:0] {
    OP_UQUO = 2'd0,
    OP_UREM = 2'd1,
    OP_SQUO = 2'd2,
    OP_SREM = 2'd3
  } op_t;

  // Control that travels with each word down the pipeline
  typedef struct packed {
    logic want_rem;  // answer is the remainder
    logic neg_q;     // negate the quotient at the end
    logic neg_r;     // negate the remainder at the end
    logic dz;        // divisor was zero
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/core/int64_divide_signed_unsigned.sv */
// int64_divide_signed_unsigned: fully pipelined signed/unsigned integer divider.
//
// Input channel (in_valid / in_stall): one word holds req_type, dividend and
// divisor. req_type picks unsigned quotient, unsigned remainder, signed
// quotient (truncated toward zero) or signed remainder (sign of dividend).
// Only the low DATA_WIDTH bits of each operand are used.
// Result channel (out_valid / out_stall): one word per input word, in order,
// holding answer (zero above DATA_WIDTH) and divide_by_zero. With a zero
// divisor the flag is set, a quotient reads all ones and a remainder reads
// the dividend. Most negative over minus one wraps to most negative.
//
// Pipeline: the accepting edge loads the input register; then come the magnitude
// stage, one restoring-division stage per quotient bit and the sign fix / select
// stage. Throughput: one word per cycle while no result is held by out_stall;
// each division stage does one (DATA_WIDTH+1)-bit subtract and compare.
// When out_stall is high while a result waits, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; payload is not reset.
`default_nettype none

module int64_divide_signed_unsigned
  import i64div_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [WORD_W-1:0]    in_dividend,
  input  wire logic [WORD_W-1:0]    in_divisor,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WORD_W-1:0]         out_answer,
  output logic                      out_divide_by_zero
);

  localparam int unsigned W = DATA_WIDTH;

  // Global advance: everything moves unless a finished word is held.
  logic adv;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // Input register: masked operands
  // ---------------------------------------------------------------------
  logic         in_vld_r;
  logic [1:0]   in_op_r;
  logic [W-1:0] in_a_r;
  logic [W-1:0] in_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_op_r <= in_req_type;
      in_a_r  <= in_dividend[W-1:0];
      in_b_r  <= in_divisor[W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Magnitude stage: decode op, take absolute values, flag zero divisor
  // ---------------------------------------------------------------------
  logic         is_signed;
  logic         want_rem;
  logic         na;
  logic         nb;
  logic [W-1:0] ua_nxt;
  logic [W-1:0] ub_nxt;
  ctl_t         ctl_nxt;

  always_comb begin
    unique case (op_t'(in_op_r))
      OP_UQUO: begin
        is_signed = 1'b0;
        want_rem  = 1'b0;
      end
      OP_UREM: begin
        is_signed = 1'b0;
        want_rem  = 1'b1;
      end
      OP_SQUO: begin
        is_signed = 1'b1;
        want_rem  = 1'b0;
      end
      OP_SREM: begin
        is_signed = 1'b1;
        want_rem  = 1'b1;
      end
      default: begin
        is_signed = 1'b0;
        want_rem  = 1'b0;
      end
    endcase
  end

  assign na     = is_signed && in_a_r[W-1];
  assign nb     = is_signed && in_b_r[W-1];
  assign ua_nxt = na ? (~in_a_r + W'(1)) : in_a_r;
  assign ub_nxt = nb ? (~in_b_r + W'(1)) : in_b_r;

  always_comb begin
    ctl_nxt.want_rem = want_rem;
    ctl_nxt.neg_q    = na ^ nb;
    ctl_nxt.neg_r    = na;
    ctl_nxt.dz       = (in_b_r == '0);
  end

  // ---------------------------------------------------------------------
  // Division pipeline: entry 0 is the magnitude stage output, entry k+1
  // holds the state after quotient bit k (MSB first).
  // ---------------------------------------------------------------------
  logic         vld_r [0:W];
  ctl_t         ctl_r [0:W];
  logic [W-1:0] rem_r [0:W];  // partial remainder
  logic [W-1:0] quo_r [0:W];  // dividend bits shifting out, quotient in
  logic [W-1:0] dvs_r [0:W];  // divisor magnitude

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_nxt;
      rem_r[0] <= '0;
      quo_r[0] <= ua_nxt;
      dvs_r[0] <= ub_nxt;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic [W-1:0] rem_nxt;
    logic [W-1:0] quo_nxt;

    // Shift in next dividend bit, try subtracting the divisor.
    assign trial   = {rem_r[k], quo_r[k][W-1]};
    assign diff    = trial - {1'b0, dvs_r[k]};
    assign rem_nxt = diff[W] ? trial[W-1:0] : diff[W-1:0];
    assign quo_nxt = {quo_r[k][W-2:0], ~diff[W]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[k+1] <= ctl_r[k];
        rem_r[k+1] <= rem_nxt;
        quo_r[k+1] <= quo_nxt;
        dvs_r[k+1] <= dvs_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: sign fix and select. A zero divisor yields quotient of
  // all ones and remainder equal to the magnitude, which after the sign
  // fix is the original dividend.
  // ---------------------------------------------------------------------
  ctl_t         ctl_end;
  logic [W-1:0] q_fix;
  logic [W-1:0] r_fix;
  logic [W-1:0] ans_w;
  logic [WORD_W-1:0] answer_nxt;
  logic [WORD_W-1:0] answer_r;
  logic              dz_r;

  assign ctl_end = ctl_r[W];
  assign q_fix   = ctl_end.neg_q ? (~quo_r[W] + W'(1)) : quo_r[W];
  assign r_fix   = ctl_end.neg_r ? (~rem_r[W] + W'(1)) : rem_r[W];

  always_comb begin
    if (ctl_end.want_rem) begin
      ans_w = r_fix;
    end else if (ctl_end.dz) begin
      ans_w = '1;
    end else begin
      ans_w = q_fix;
    end
  end

  assign answer_nxt = WORD_W'(ans_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      answer_r <= answer_nxt;
      dz_r     <= ctl_end.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_answer         = answer_r;
  assign out_divide_by_zero = dz_r;

endmodule

`default_nettype wire

/* rtl/core/i64div_chk.sv */
// i64div_chk: port-level assertions for int64_divide_signed_unsigned.
// Depends on i64div_pkg; bound to the divider top level at the end of file.
`default_nettype none

module i64div_chk
  import i64div_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [1:0]        in_req_type,
  input wire logic [WORD_W-1:0] in_dividend,
  input wire logic [WORD_W-1:0] in_divisor,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [WORD_W-1:0] out_answer,
  input wire logic              out_divide_by_zero
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Pipe freezes exactly when a result word is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the held result word");

  // Answer bits above the working width stay zero.
  a_answer_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_answer >> DATA_WIDTH) == '0))
    else $error("answer has bits set above DATA_WIDTH");

  // A held result word keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_answer) && $stable(out_divide_by_zero))
    else $error("held result word changed");

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable(in_req_type) && $stable(in_dividend) &&
      $stable(in_divisor))
    else $error("stalled input word changed");

endmodule

bind int64_divide_signed_unsigned i64div_chk #(
  .DATA_WIDTH(DATA_WIDTH)
) u_i64div_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_req_type       (in_req_type),
  .in_dividend       (in_dividend),
  .in_divisor        (in_divisor),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_answer        (out_answer),
  .out_divide_by_zero(out_divide_by_zero)
);

`default_nettype wire

/* tb/sv/int64_divide_signed_unsigned_test.sv */
// Self-checking testbench for int64_divide_signed_unsigned: random and edge-case divisions,
// with each answer predicted and compared in a small scoreboard class.
// Depends on i64div_pkg and the divider RTL only.
module int64_divide_signed_unsigned_test;
  import i64div_pkg::*;

  // Drain wait after the last answer, sized to the divider pipeline.
  localparam int unsigned LATENCY     = WORD_W + 2;
  // Watchdog limit, with a wide margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] MOST_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // Edge-case operand pairs, each sent once per operation:
  // zero divisor, most negative over minus one, all ones over one,
  // largest positive over most negative, minus seven over two, 13 over minus four.
  localparam logic [WORD_W-1:0] EDGE_DIVIDEND [6] =
    '{MOST_NEG, MOST_NEG, ALL_ONES, MOST_POS, ALL_ONES - WORD_W'(6), WORD_W'(13)};
  localparam logic [WORD_W-1:0] EDGE_DIVISOR [6] =
    '{'0, ALL_ONES, WORD_W'(1), MOST_NEG, WORD_W'(2), ALL_ONES - WORD_W'(3)};

  // One expected answer, with the operands kept for the mismatch line.
  typedef struct {
    op_t               op;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
    logic [WORD_W-1:0] answer;
    logic              divide_by_zero;
  } div_expect_t;

  // Scoreboard: predicts the answer of each accepted word and checks results in order.
  class div_checker;
    div_expect_t pending_answers[$];
    int unsigned mismatches;

    function logic [WORD_W-1:0] negate(logic [WORD_W-1:0] v);
      return ~v + WORD_W'(1);
    endfunction

    // Signed forms divide magnitudes, then fix the sign: the quotient is negative
    // when the signs differ, the remainder follows the dividend. Unsigned forms
    // see both signs as positive, so the same path serves them.
    function void note_division(op_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      div_expect_t       e;
      logic              want_rem;
      logic              is_signed;
      logic              neg_a;
      logic              neg_b;
      logic [WORD_W-1:0] mag_a;
      logic [WORD_W-1:0] mag_b;
      logic [WORD_W-1:0] quo;
      logic [WORD_W-1:0] rem;
      want_rem  = (op == OP_UREM) || (op == OP_SREM);
      is_signed = (op == OP_SQUO) || (op == OP_SREM);
      neg_a = is_signed && a[WORD_W-1];
      neg_b = is_signed && b[WORD_W-1];
      // most negative keeps its bit pattern, which read unsigned is its magnitude
      mag_a = neg_a ? negate(a) : a;
      mag_b = neg_b ? negate(b) : b;
      e.op = op;
      e.dividend = a;
      e.divisor = b;
      e.divide_by_zero = (b == '0);
      if (e.divide_by_zero) begin
        // zero divisor: quotient reads all ones, remainder reads the dividend
        e.answer = want_rem ? a : ALL_ONES;
      end else begin
        quo = mag_a / mag_b;
        rem = mag_a % mag_b;
        if (want_rem) begin
          e.answer = neg_a ? negate(rem) : rem;
        end else begin
          // most negative over minus one lands back on most negative here
          e.answer = (neg_a != neg_b) ? negate(quo) : quo;
        end
      end
      pending_answers.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_answer(logic [WORD_W-1:0] answer, logic dz);
      div_expect_t e;
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected word: answer %h dz %b", answer, dz));
        return;
      end
      e = pending_answers.pop_front();
      if (answer !== e.answer)
        report($sformatf("%s %h / %h: answer %h, want %h",
                         e.op.name(), e.dividend, e.divisor, answer, e.answer));
      if (dz !== e.divide_by_zero)
        report($sformatf("%s %h / %h: divide_by_zero %b, want %b",
                         e.op.name(), e.dividend, e.divisor, dz, e.divide_by_zero));
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = '0;
  logic [WORD_W-1:0] in_dividend = '0;
  logic [WORD_W-1:0] in_divisor = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_answer;
  logic              out_divide_by_zero;

  // Idle rates in percent per cycle, set per phase by the main sequence.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  // While set, the receiver stalls every cycle (long hold-off to fill the pipe).
  logic        rx_hold = 1'b0;
  int unsigned words_accepted = 0;
  int unsigned cycle_count = 0;

  div_checker book = new;

  int64_divide_signed_unsigned #(
    .DATA_WIDTH(WORD_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_dividend       (in_dividend),
    .in_divisor        (in_divisor),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_answer        (out_answer),
    .out_divide_by_zero(out_divide_by_zero)
  );

  always #10 clk = ~clk;

  // Monitor: at the rising edge, before the block's own updates land, so both
  // handshakes are seen exactly as the block sees them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        book.note_division(op_t'(in_req_type), in_dividend, in_divisor);
        words_accepted <= words_accepted + 1;
      end
      if (out_valid && !out_stall)
        book.check_answer(out_answer, out_divide_by_zero);
    end
  end

  // Receiver: one stall decision per falling edge, one assignment per step.
  always @(negedge clk) begin
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Back-pressure: once the no-idle phase is running, the receiver holds off for
  // a long stretch while the sender keeps offering, so the pipeline fills and
  // in_stall must rise.
  initial begin
    wait (words_accepted >= 1400);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one word at a falling edge, after a random number of idle cycles.
  // Valid stays high across back-to-back words, so it gets one assignment per step.
  task automatic send_word(op_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_dividend <= a;
    in_divisor  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Operand mix: zero, one, the sign extremes, small values of both signs and
  // random values of random length, so quotients of every size come up.
  function automatic logic [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return WORD_W'(1);
      2: return ALL_ONES;
      3: return MOST_NEG;
      4: return MOST_POS;
      5: return WORD_W'($urandom_range(1000, 1));
      6: return ALL_ONES - WORD_W'($urandom_range(999));
      7, 8: return full >> $urandom_range(WORD_W - 1);
      default: return full;
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_word(op_t'($urandom_range(int'(OP_SREM))), pick_operand(), pick_operand());
  endtask

  // Main sequence: reset, edge cases, then three random phases with different
  // idle patterns, then drain and verdict.
  initial begin
    op_t op;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 12;
    rx_idle_pct = 62;
    for (int i = 0; i < 6; i++) begin
      op = op.first();
      do begin
        send_word(op, EDGE_DIVIDEND[i], EDGE_DIVISOR[i]);
        op = op.next();
      end while (op != op.first());
    end
    run_random(625);

    tx_idle_pct = 62;
    rx_idle_pct = 12;
    run_random(625);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(626);
    in_valid <= 1'b0;

    // wait for every answer, then a pipeline's worth of cycles for strays
    while (book.pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    if (book.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
